// ===== rtl/vprm_pkg.sv =====
package vprm_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_X_START       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_START       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_X_END         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_END         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_FORMAT = 3'd6;

    // Chroma formats
    localparam logic [1:0] FMT_GREY = 2'd0;
    localparam logic [1:0] FMT_420  = 2'd1;
    localparam logic [1:0] FMT_422  = 2'd2;
    localparam logic [1:0] FMT_PASS = 2'd3;

    // Plane codes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // Fill values inside the rectangle
    localparam logic [7:0] MASK_LUMA   = 8'd0;
    localparam logic [7:0] MASK_CHROMA = 8'd128;

    // Register reset values
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

    // Cycles from a register write until the geometry outputs are current
    localparam int GEOM_LATENCY = 3;

    // Format flags carried along the geometry pipeline
    typedef struct packed {
        logic mask_en;       // rectangle not empty and format supported
        logic three_planes;  // 4:2:0 or 4:2:2
        logic half_rows;     // chroma rows halved (4:2:0)
    } geom_ctl_t;

endpackage

// ===== rtl/vprm_geom.sv =====
module vprm_geom #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vprm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vprm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output vprm_pkg::geom_ctl_t               ctl,
    output logic [WW-1:0]                     luma_pw,
    output logic [WW-1:0]                     chroma_pw,
    output logic [HW-1:0]                     luma_ph,
    output logic [HW-1:0]                     chroma_ph,
    output logic [WW-1:0]                     luma_x_org,
    output logic [WW-1:0]                     luma_x_end,
    output logic [WW-1:0]                     chroma_x_org,
    output logic [WW-1:0]                     chroma_x_end,
    output logic [HW-1:0]                     luma_y_org,
    output logic [HW-1:0]                     luma_y_end,
    output logic [HW-1:0]                     chroma_y_org,
    output logic [HW-1:0]                     chroma_y_end
);

    // Configuration registers
    logic [15:0] x_start_reg;
    logic [15:0] y_start_reg;
    logic [16:0] x_end_reg;
    logic [16:0] y_end_reg;
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [1:0]  chroma_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_start_reg       <= '0;
            y_start_reg       <= '0;
            x_end_reg         <= '0;
            y_end_reg         <= '0;
            frame_width_reg   <= vprm_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= vprm_pkg::RST_FRAME_HEIGHT;
            chroma_format_reg <= vprm_pkg::FMT_GREY;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vprm_pkg::REG_X_START:       x_start_reg       <= cfg_wdata[15:0];
                vprm_pkg::REG_Y_START:       y_start_reg       <= cfg_wdata[15:0];
                vprm_pkg::REG_X_END:         x_end_reg         <= cfg_wdata[16:0];
                vprm_pkg::REG_Y_END:         y_end_reg         <= cfg_wdata[16:0];
                vprm_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[12:0];
                vprm_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[12:0];
                vprm_pkg::REG_CHROMA_FORMAT: chroma_format_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: effective frame size, extents, format flags
    logic [WW-1:0]       w_next;
    logic [HW-1:0]       h_next;
    vprm_pkg::geom_ctl_t ctl1_next;

    always_comb begin
        if (32'(frame_width_reg) > MAX_WIDTH) begin
            w_next = WW'(MAX_WIDTH);
        end else if (frame_width_reg < 13'd2) begin
            w_next = WW'(2);
        end else begin
            w_next = WW'(frame_width_reg);
        end
        w_next[0] = 1'b0;

        if (32'(frame_height_reg) > MAX_HEIGHT) begin
            h_next = HW'(MAX_HEIGHT);
        end else if (frame_height_reg < 13'd2) begin
            h_next = HW'(2);
        end else begin
            h_next = HW'(frame_height_reg);
        end
        h_next[0] = 1'b0;

        ctl1_next.mask_en      = (chroma_format_reg != vprm_pkg::FMT_PASS) &&
                                 (x_end_reg > {1'b0, x_start_reg}) &&
                                 (y_end_reg > {1'b0, y_start_reg});
        ctl1_next.three_planes = (chroma_format_reg == vprm_pkg::FMT_420) ||
                                 (chroma_format_reg == vprm_pkg::FMT_422);
        ctl1_next.half_rows    = (chroma_format_reg == vprm_pkg::FMT_420);
    end

    logic [WW-1:0]       w1_reg;
    logic [HW-1:0]       h1_reg;
    logic [15:0]         xs1_reg;
    logic [15:0]         ys1_reg;
    logic [16:0]         dx1_reg;
    logic [16:0]         dy1_reg;
    vprm_pkg::geom_ctl_t ctl1_reg;

    always_ff @(posedge aclk) begin
        w1_reg   <= w_next;
        h1_reg   <= h_next;
        xs1_reg  <= x_start_reg;
        ys1_reg  <= y_start_reg;
        dx1_reg  <= x_end_reg - {1'b0, x_start_reg};
        dy1_reg  <= y_end_reg - {1'b0, y_start_reg};
        ctl1_reg <= ctl1_next;
    end

    // Stage 2: scale the fractions by the frame size
    logic [16+WW-1:0] px_prod;
    logic [17+WW-1:0] sx_prod;
    logic [16+HW-1:0] py_prod;
    logic [17+HW-1:0] sy_prod;

    assign px_prod = (16+WW)'(xs1_reg) * (16+WW)'(w1_reg);
    assign sx_prod = (17+WW)'(dx1_reg) * (17+WW)'(w1_reg);
    assign py_prod = (16+HW)'(ys1_reg) * (16+HW)'(h1_reg);
    assign sy_prod = (17+HW)'(dy1_reg) * (17+HW)'(h1_reg);

    logic [WW-1:0]       posx2_reg;
    logic [WW-1:0]       sizex2_reg;
    logic [HW-1:0]       posy2_reg;
    logic [HW-1:0]       sizey2_reg;
    logic [WW-1:0]       w2_reg;
    logic [HW-1:0]       h2_reg;
    vprm_pkg::geom_ctl_t ctl2_reg;

    always_ff @(posedge aclk) begin
        posx2_reg  <= px_prod[16 +: WW];
        sizex2_reg <= sx_prod[16 +: WW];
        posy2_reg  <= py_prod[16 +: HW];
        sizey2_reg <= sy_prod[16 +: HW];
        w2_reg     <= w1_reg;
        h2_reg     <= h1_reg;
        ctl2_reg   <= ctl1_reg;
    end

    // Stage 3: even origin, size clipped to the frame, chroma scaling
    logic [WW-1:0] ox, roomx, lx, endx;
    logic [HW-1:0] oy, roomy, ly, endy;

    always_comb begin
        ox    = {posx2_reg[WW-1:1], 1'b0};
        roomx = w2_reg - ox;
        lx    = (sizex2_reg < roomx) ? sizex2_reg : roomx;
        lx[0] = 1'b0;
        endx  = ox + lx;

        oy    = {posy2_reg[HW-1:1], 1'b0};
        roomy = h2_reg - oy;
        ly    = (sizey2_reg < roomy) ? sizey2_reg : roomy;
        ly[0] = 1'b0;
        endy  = oy + ly;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl <= '0;
        end else begin
            ctl <= ctl2_reg;
        end
        luma_pw      <= w2_reg;
        chroma_pw    <= w2_reg >> 1;
        luma_ph      <= h2_reg;
        chroma_ph    <= ctl2_reg.half_rows ? (h2_reg >> 1) : h2_reg;
        luma_x_org   <= ox;
        luma_x_end   <= endx;
        chroma_x_org <= ox >> 1;
        chroma_x_end <= endx >> 1;
        luma_y_org   <= oy;
        luma_y_end   <= endy;
        chroma_y_org <= ctl2_reg.half_rows ? (oy >> 1) : oy;
        chroma_y_end <= ctl2_reg.half_rows ? (endy >> 1) : endy;
    end

endmodule

// ===== rtl/video_privacy_rect_mask_unit.sv =====
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_pixel_in, s_frame_start
// m_       | out       | m_valid / m_ready  | m_pixel_out, m_plane_id, m_was_masked,
//          |           |                    | m_frame_end
// cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One byte per cycle while m_ready is high and no write settles; results are registered.
// The byte is classified by comparing the position counters with registered rectangle
// bounds, so the per-byte path is two compare pairs and a counter increment.
// A register write or reset reloads a 3-stage geometry pipeline (frame size and extents,
// scale, clip and chroma divide); s_ready stays low while the settle counter runs down,
// so the next transfer waits until the new geometry outputs are current.
// A stalled m_ready holds the result register; the input register still takes one byte.
module video_privacy_rect_mask_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [vprm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vprm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_pixel_in,
    input  logic                              s_frame_start,
    // result stream
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_pixel_out,
    output logic [1:0]                        m_plane_id,
    output logic                              m_was_masked,
    output logic                              m_frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [1:0] SETTLE_LOAD = 2'(vprm_pkg::GEOM_LATENCY - 1);

    // Geometry
    vprm_pkg::geom_ctl_t ctl;
    logic [WW-1:0] luma_pw, chroma_pw, luma_x_org, luma_x_end, chroma_x_org, chroma_x_end;
    logic [HW-1:0] luma_ph, chroma_ph, luma_y_org, luma_y_end, chroma_y_org, chroma_y_end;

    vprm_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .ctl          (ctl),
        .luma_pw      (luma_pw),
        .chroma_pw    (chroma_pw),
        .luma_ph      (luma_ph),
        .chroma_ph    (chroma_ph),
        .luma_x_org   (luma_x_org),
        .luma_x_end   (luma_x_end),
        .chroma_x_org (chroma_x_org),
        .chroma_x_end (chroma_x_end),
        .luma_y_org   (luma_y_org),
        .luma_y_end   (luma_y_end),
        .chroma_y_org (chroma_y_org),
        .chroma_y_end (chroma_y_end)
    );

    // Settle counter: hold off transfers while the geometry pipeline refills
    logic [1:0] settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            settle_reg <= SETTLE_LOAD;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // Handshake between input register and result register
    logic       in_valid_reg;
    logic [7:0] in_pixel_reg;
    logic       in_fs_reg;
    logic       out_free;
    logic       advance;

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = (settle_reg == 2'd0) && (!in_valid_reg || out_free);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_pixel_reg <= s_pixel_in;
            in_fs_reg    <= s_frame_start;
        end
    end

    // Position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    plane_reg, plane_next;

    // Classification of the byte in the input register
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [1:0]    plane_cur;
    logic          chroma;
    logic [WW-1:0] pw, x_org, x_end;
    logic [HW-1:0] ph, y_org, y_end;
    logic [WW:0]   col_inc;
    logic [HW:0]   row_inc;
    logic          col_wrap, row_wrap, last_plane, hit;
    logic [7:0]    pixel_res;

    always_comb begin
        col_cur   = in_fs_reg ? '0 : col_reg;
        row_cur   = in_fs_reg ? '0 : row_reg;
        plane_cur = in_fs_reg ? vprm_pkg::PLANE_Y : plane_reg;
        // plane count beyond the format's last plane restarts at luma
        if (ctl.three_planes ? (plane_cur > vprm_pkg::PLANE_V)
                             : (plane_cur != vprm_pkg::PLANE_Y)) begin
            plane_cur = vprm_pkg::PLANE_Y;
        end
        chroma = (plane_cur != vprm_pkg::PLANE_Y);

        pw    = chroma ? chroma_pw    : luma_pw;
        ph    = chroma ? chroma_ph    : luma_ph;
        x_org = chroma ? chroma_x_org : luma_x_org;
        x_end = chroma ? chroma_x_end : luma_x_end;
        y_org = chroma ? chroma_y_org : luma_y_org;
        y_end = chroma ? chroma_y_end : luma_y_end;

        hit = ctl.mask_en &&
              ((WW+1)'(col_cur) >= (WW+1)'(x_org)) && ((WW+1)'(col_cur) < (WW+1)'(x_end)) &&
              ((HW+1)'(row_cur) >= (HW+1)'(y_org)) && ((HW+1)'(row_cur) < (HW+1)'(y_end));

        if (hit) begin
            pixel_res = chroma ? vprm_pkg::MASK_CHROMA : vprm_pkg::MASK_LUMA;
        end else begin
            pixel_res = in_pixel_reg;
        end

        // raster advance
        col_inc    = (WW+1)'(col_cur) + (WW+1)'(1);
        row_inc    = (HW+1)'(row_cur) + (HW+1)'(1);
        col_wrap   = col_inc >= (WW+1)'(pw);
        row_wrap   = row_inc >= (HW+1)'(ph);
        last_plane = !ctl.three_planes || (plane_cur == vprm_pkg::PLANE_V);

        col_next   = col_wrap ? '0 : col_inc[CW-1:0];
        row_next   = row_cur;
        plane_next = plane_cur;
        if (col_wrap) begin
            row_next = row_wrap ? '0 : row_inc[RW-1:0];
            if (row_wrap) begin
                plane_next = last_plane ? vprm_pkg::PLANE_Y : plane_cur + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= vprm_pkg::PLANE_Y;
        end else if (advance) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
        if (advance) begin
            m_pixel_out  <= pixel_res;
            m_plane_id   <= plane_cur;
            m_was_masked <= hit;
            m_frame_end  <= col_wrap && row_wrap && last_plane;
        end
    end

`ifndef SYNTHESIS
    // A masked byte carries the fill value of its plane
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_masked |->
            (m_plane_id == vprm_pkg::PLANE_Y && m_pixel_out == vprm_pkg::MASK_LUMA) ||
            (m_plane_id != vprm_pkg::PLANE_Y && m_pixel_out == vprm_pkg::MASK_CHROMA))
        else $error("masked byte with wrong fill value");

    // No transfer while the geometry is being recomputed after a write
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready ##1 !s_ready)
        else $error("input taken before geometry settled");

    // Plane code stays within the three planes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_plane_id != 2'd3)
        else $error("invalid plane code");

    // Outside the luma plane the format must have chroma planes
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && plane_cur != vprm_pkg::PLANE_Y |-> ctl.three_planes)
        else $error("chroma plane in single-plane format");
`endif

endmodule
